@@ rtl/trbdf_pkg.sv @@
// Package with the shared types and codes of the transmit ring-buffer DMA feeder.
package trbdf_pkg;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_DONE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REJECT  = 2'd1;
  localparam logic [1:0] ST_DROP    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef enum logic [1:0] {
    KIND_DONE,
    KIND_HEAD,
    KIND_BODY
  } kind_t;

  typedef struct packed {
    logic        cmd;
    logic        first;
    logic [15:0] msg_length;
    logic [7:0]  data_byte;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        mem_write;
    logic [11:0] mem_addr;
    logic [7:0]  mem_data;
    logic        dma_start;
    logic [11:0] dma_offset;
    logic [12:0] dma_length;
  } out_result_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } entry_t;

endpackage

@@ rtl/trbdf_front.sv @@
// Front end: takes command beats, classifies them and holds them in a two-entry queue.
module trbdf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  trbdf_pkg::in_item_t in_item,
  output logic                q_valid,
  output trbdf_pkg::entry_t   q_entry
);

  trbdf_pkg::entry_t q_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        count_r;
  logic              push;
  logic              pop;
  trbdf_pkg::entry_t new_entry;

  always_comb begin
    new_entry.item = in_item;
    if (in_item.cmd == trbdf_pkg::CMD_DONE) begin
      new_entry.kind = trbdf_pkg::KIND_DONE;
    end else if (in_item.first) begin
      new_entry.kind = trbdf_pkg::KIND_HEAD;
    end else begin
      new_entry.kind = trbdf_pkg::KIND_BODY;
    end
  end

  assign busy    = (count_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count_r != 2'd0);
  assign pop     = q_valid;
  assign q_entry = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_entry;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

@@ rtl/trbdf_back.sv @@
// Back end: ring pointer bookkeeping, memory write strobes and DMA chunk issue.
module trbdf_back #(
  parameter int RING_SIZE = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  trbdf_pkg::entry_t      q_entry,
  output logic                   out_valid,
  output trbdf_pkg::out_result_t out_result
);

  localparam int PTR_W = $clog2(RING_SIZE);
  localparam int LW    = PTR_W + 1;
  localparam int CW    = (LW > 16) ? LW : 16;

  logic [PTR_W-1:0] read_ptr_r, read_ptr_nxt;
  logic [PTR_W-1:0] committed_wp_r, committed_wp_nxt;
  logic [PTR_W-1:0] fill_ptr_r, fill_ptr_nxt;
  logic [PTR_W-1:0] next_read_ptr_r, next_read_ptr_nxt;
  logic             dma_busy_r, dma_busy_nxt;
  logic             msg_accepting_r, msg_accepting_nxt;
  logic [15:0]      bytes_remaining_r, bytes_remaining_nxt;
  logic             out_valid_r;
  trbdf_pkg::out_result_t out_result_r, out_result_nxt;

  logic [LW-1:0]    free_space;
  logic             too_long;
  logic             take;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] fill_inc;
  logic [15:0]      br_dec;
  logic             commit;
  logic             try_go;
  logic [LW-1:0]    chunk_len;
  logic [31:0]      addr_ext;
  logic [31:0]      off_ext;
  logic [31:0]      len_ext;

  always_comb begin
    if (committed_wp_r >= read_ptr_r) begin
      free_space = LW'(RING_SIZE - 1) + LW'(read_ptr_r) - LW'(committed_wp_r);
    end else begin
      free_space = LW'(read_ptr_r) - LW'(committed_wp_r) - LW'(1);
    end
    too_long = (q_entry.item.msg_length == 16'd0) ||
               (CW'(q_entry.item.msg_length) > CW'(free_space));
  end

  always_comb begin
    read_ptr_nxt        = read_ptr_r;
    committed_wp_nxt    = committed_wp_r;
    fill_ptr_nxt        = fill_ptr_r;
    next_read_ptr_nxt   = next_read_ptr_r;
    dma_busy_nxt        = dma_busy_r;
    msg_accepting_nxt   = msg_accepting_r;
    bytes_remaining_nxt = bytes_remaining_r;
    out_result_nxt      = '0;
    take                = 1'b0;
    try_go              = 1'b0;
    wr_addr             = fill_ptr_r;
    fill_inc            = '0;
    br_dec              = 16'd0;
    commit              = 1'b0;
    chunk_len           = '0;
    addr_ext            = 32'd0;
    off_ext             = 32'd0;
    len_ext             = 32'd0;

    if (q_valid) begin
      case (q_entry.kind)
        trbdf_pkg::KIND_DONE: begin
          if (dma_busy_r) begin
            read_ptr_nxt = next_read_ptr_r;
            dma_busy_nxt = 1'b0;
            try_go       = 1'b1;
          end else begin
            out_result_nxt.status = trbdf_pkg::ST_IGNORED;
          end
        end
        trbdf_pkg::KIND_HEAD: begin
          msg_accepting_nxt = 1'b0;
          wr_addr           = committed_wp_r;
          if (too_long) begin
            out_result_nxt.status = trbdf_pkg::ST_REJECT;
            fill_ptr_nxt          = committed_wp_r;
          end else begin
            take   = 1'b1;
            br_dec = q_entry.item.msg_length - 16'd1;
          end
        end
        trbdf_pkg::KIND_BODY: begin
          if (msg_accepting_r) begin
            take   = 1'b1;
            br_dec = (bytes_remaining_r != 16'd0) ? bytes_remaining_r - 16'd1 : 16'd0;
          end else begin
            out_result_nxt.status = trbdf_pkg::ST_DROP;
          end
        end
        default: begin
          out_result_nxt.status = trbdf_pkg::ST_DROP;
        end
      endcase

      if (take) begin
        fill_inc = (wr_addr == PTR_W'(RING_SIZE - 1)) ? '0 : wr_addr + PTR_W'(1);
        addr_ext = 32'(wr_addr);
        out_result_nxt.mem_write = 1'b1;
        out_result_nxt.mem_addr  = addr_ext[11:0];
        out_result_nxt.mem_data  = q_entry.item.data_byte;
        fill_ptr_nxt        = fill_inc;
        bytes_remaining_nxt = br_dec;
        msg_accepting_nxt   = 1'b1;
        commit = (br_dec == 16'd0) || q_entry.item.last;
        if (commit) begin
          committed_wp_nxt    = fill_inc;
          msg_accepting_nxt   = 1'b0;
          bytes_remaining_nxt = 16'd0;
          try_go              = !dma_busy_r;
        end
      end

      if (try_go && (read_ptr_nxt != committed_wp_nxt)) begin
        if (read_ptr_nxt > committed_wp_nxt) begin
          chunk_len         = LW'(RING_SIZE) - LW'(read_ptr_nxt);
          next_read_ptr_nxt = '0;
        end else begin
          chunk_len         = LW'(committed_wp_nxt) - LW'(read_ptr_nxt);
          next_read_ptr_nxt = committed_wp_nxt;
        end
        dma_busy_nxt = 1'b1;
        off_ext      = 32'(read_ptr_nxt);
        len_ext      = 32'(chunk_len);
        out_result_nxt.dma_start  = 1'b1;
        out_result_nxt.dma_offset = off_ext[11:0];
        out_result_nxt.dma_length = len_ext[12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    if (!rst_n) begin
      read_ptr_r        <= '0;
      committed_wp_r    <= '0;
      fill_ptr_r        <= '0;
      next_read_ptr_r   <= '0;
      dma_busy_r        <= 1'b0;
      msg_accepting_r   <= 1'b0;
      bytes_remaining_r <= 16'd0;
      out_valid_r       <= 1'b0;
    end else begin
      read_ptr_r        <= read_ptr_nxt;
      committed_wp_r    <= committed_wp_nxt;
      fill_ptr_r        <= fill_ptr_nxt;
      next_read_ptr_r   <= next_read_ptr_nxt;
      dma_busy_r        <= dma_busy_nxt;
      msg_accepting_r   <= msg_accepting_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
      out_valid_r       <= q_valid;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

@@ rtl/tx_ring_buffer_dma_feeder.sv @@
// Top level of the transmit ring-buffer DMA feeder.
// A beat is taken on each clock edge with start high and busy low, and every beat
// (message byte or DMA completion) yields exactly one result, passing through the
// queue and then the back-end output register, shown for one cycle with out_valid high.
// The receiver cannot stall the block. The back end retires one queued beat per
// clock, so one beat per cycle is sustained, a rate set by its pointer update, and
// busy rises only when the two-entry queue between the front and back ends is full.
module tx_ring_buffer_dma_feeder #(
  parameter int RING_SIZE = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  trbdf_pkg::in_item_t    in_item,
  output logic                   out_valid,
  output trbdf_pkg::out_result_t out_result
);

  logic              q_valid;
  trbdf_pkg::entry_t q_entry;

  trbdf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_entry (q_entry)
  );

  trbdf_back #(
    .RING_SIZE (RING_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> q_valid)
    else $error("accepted beat did not reach the queue");

  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |=> out_valid)
    else $error("queued beat produced no result");

  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.mem_write) |-> (out_result.status == trbdf_pkg::ST_OK))
    else $error("memory write with non-ok status");

endmodule
